@@ sv/ring_chain_rotation_transform_core_defines.svh @@
// Assertion macros for the ring chain rotation transform core.
// The simulation form reports through $error; the synthesis form is empty.
`ifndef RING_CHAIN_ROTATION_TRANSFORM_CORE_DEFINES_SVH
`define RING_CHAIN_ROTATION_TRANSFORM_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define RCRT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define RCRT_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define RCRT_ASSERT(label, prop, msg)
`define RCRT_ASSERT_NEVER(label, cond, msg)
`endif

`endif

@@ sv/rcrt_pkg.sv @@
`default_nettype none
package rcrt_pkg;

    localparam int RING_STEPS = 40;
    localparam int NVERT      = RING_STEPS + 1;
    localparam int VW         = $clog2(NVERT);
    localparam int DIV        = RING_STEPS - 1;
    localparam int ARW        = $clog2(2 * DIV + 1);
    localparam int CSTAGES    = 30;
    localparam int CSW        = $clog2(CSTAGES);

    typedef logic signed [67:0] t_wide;
    typedef logic signed [34:0] t_ang;

    localparam t_ang PI_A      = 35'sd3373259426;
    localparam t_ang HALF_PI_A = 35'sd1686629713;
    localparam t_ang TWO_PI_A  = 35'sd6746518852;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [31:0] Q30_ONE     = 32'sd1073741824;

    // angle step of the circle table: 2*pi / DIV as quotient and remainder
    localparam longint ANG_TOTAL  = 64'd6746518852;
    localparam longint ANG_STEP_Q = ANG_TOTAL / DIV;
    localparam longint ANG_STEP_R = ANG_TOTAL % DIV;
    localparam longint ANG_REM0   = DIV / 2;

    localparam logic [1:0] CFG_RING_SPACING = 2'd0;
    localparam logic [1:0] CFG_RING_RADIUS  = 2'd1;

    localparam logic [24:0] SPACING_RST = 25'd262144;
    localparam logic [24:0] RADIUS_RST  = 25'd1310720;

    function automatic t_ang atan_rom(input logic [CSW-1:0] i);
        t_ang v;
        case (i)
            5'd0:  v = 35'sd843314857;
            5'd1:  v = 35'sd497837830;
            5'd2:  v = 35'sd263043837;
            5'd3:  v = 35'sd133525159;
            5'd4:  v = 35'sd67021687;
            5'd5:  v = 35'sd33543516;
            5'd6:  v = 35'sd16775851;
            5'd7:  v = 35'sd8388437;
            5'd8:  v = 35'sd4194283;
            5'd9:  v = 35'sd2097149;
            5'd10: v = 35'sd1048576;
            5'd11: v = 35'sd524288;
            5'd12: v = 35'sd262144;
            5'd13: v = 35'sd131072;
            5'd14: v = 35'sd65536;
            5'd15: v = 35'sd32768;
            5'd16: v = 35'sd16384;
            5'd17: v = 35'sd8192;
            5'd18: v = 35'sd4096;
            5'd19: v = 35'sd2048;
            5'd20: v = 35'sd1024;
            5'd21: v = 35'sd512;
            5'd22: v = 35'sd256;
            5'd23: v = 35'sd128;
            5'd24: v = 35'sd64;
            5'd25: v = 35'sd32;
            5'd26: v = 35'sd16;
            5'd27: v = 35'sd8;
            5'd28: v = 35'sd4;
            5'd29: v = 35'sd2;
            default: v = 35'sd0;
        endcase
        return v;
    endfunction

    // round half up, then floor shift by 30
    function automatic t_wide rnd30(input t_wide v);
        return (v + 68'sd536870912) >>> 30;
    endfunction

    function automatic logic signed [31:0] sat32(input t_wide v);
        logic signed [31:0] r;
        if (v > 68'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -68'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [27:0] sat28(input t_wide v);
        logic signed [27:0] r;
        if (v > 68'sd134217727)
            r = 28'sh7ffffff;
        else if (v < -68'sd134217728)
            r = 28'sh8000000;
        else
            r = v[27:0];
        return r;
    endfunction

    function automatic logic signed [31:0] satq30(input t_wide v);
        logic signed [31:0] r;
        if (v > 68'sd1073741824)
            r = Q30_ONE;
        else if (v < -68'sd1073741824)
            r = -Q30_ONE;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

@@ sv/ring_chain_rotation_transform_core.sv @@
`default_nettype none
// Each ring yields 41 vertices, one after another; one ring at a time.
// The rate is set by the single shared 33x33 multiplier.
// Reset (synchronous, active low) clears the matrix to identity, the midpoint to zero
// and loads register defaults, then fills the circle table of 41 entries with the CORDIC,
// during which no input beat is taken.
`include "ring_chain_rotation_transform_core_defines.svh"
module ring_chain_rotation_transform_core import rcrt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_restart,
    input  logic signed [27:0]  i_start_z,
    input  logic signed [31:0]  i_axis_x,
    input  logic signed [31:0]  i_axis_y,
    input  logic signed [31:0]  i_rotation_angle,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [27:0]  o_pos_x,
    output logic signed [27:0]  o_pos_y,
    output logic signed [27:0]  o_pos_z,
    output logic signed [31:0]  o_norm_x,
    output logic signed [31:0]  o_norm_y,
    output logic signed [31:0]  o_norm_z,
    output logic [5:0]          o_vertex_index,
    output logic                o_last_vertex,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [24:0]         i_cfg_data
);

    typedef enum logic [3:0] {
        S_TAB_LD, S_FOLD, S_CORD, S_CEND, S_TAB_WR, S_IDLE, S_ROT, S_MAT,
        S_MID, S_VRD, S_VRAD, S_VDOT, S_OUT, S_LOWER
    } t_state;

    t_state r_state;
    logic   r_ph;          // 0: issue product, 1: write back
    logic   r_init;        // table fill in progress
    logic [2:0] r_u;
    logic [1:0] r_r, r_k, r_i;
    logic [VW-1:0] r_vi;

    logic [24:0] r_spacing, r_radius;

    // table angle as quotient/remainder of i * 2pi / DIV
    t_ang           r_aq;
    logic [ARW-1:0] r_arem;

    // CORDIC shift-add unit
    logic signed [33:0] r_cx, r_cy;
    t_ang               r_ca;
    logic               r_cneg;
    logic [CSW-1:0]     r_cstep;
    logic signed [31:0] r_c, r_s;
    logic signed [32:0] r_t;

    logic signed [31:0] r_ax, r_ay, r_xx, r_xy, r_yy;
    logic signed [31:0] r_mat [9];
    logic signed [31:0] r_rot [9];
    logic signed [31:0] r_row [2];
    logic signed [27:0] r_mid [3];
    logic signed [27:0] r_nmid [2];
    logic signed [31:0] r_cxv, r_cyv;

    logic signed [65:0] r_prod;
    t_wide              r_acc;

    logic signed [27:0] r_pos [3];
    logic signed [31:0] r_norm [3];

    logic signed [31:0] r_tab_cos [NVERT];
    logic signed [31:0] r_tab_sin [NVERT];
    logic signed [31:0] r_tcos, r_tsin;

    // shared multiplier operands
    logic signed [32:0] mul_a, mul_b;
    logic [3:0] mrow, mat_idx, rot_idx;
    t_wide prod_w, v30, acc_in, sum_r, sum_p, sum_m;

    logic signed [33:0] cx_sh, cy_sh, cx_nx, cy_nx;
    t_ang ca_nx, ang_wrap;
    logic signed [31:0] cl_x, cl_y;

    logic in_beat, out_beat;

    assign in_beat  = i_in_valid && o_in_ready;
    assign out_beat = o_out_valid && i_out_ready;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_cfg_ready = 1'b1;

    assign o_pos_x  = r_pos[0];
    assign o_pos_y  = r_pos[1];
    assign o_pos_z  = r_pos[2];
    assign o_norm_x = r_norm[0];
    assign o_norm_y = r_norm[1];
    assign o_norm_z = r_norm[2];
    assign o_vertex_index = 6'(r_vi);
    assign o_last_vertex  = (r_vi == VW'(NVERT - 1));

    // CORDIC iteration: one micro-rotation per cycle
    always_comb begin
        cx_sh = r_cx >>> r_cstep;
        cy_sh = r_cy >>> r_cstep;
        if (!r_ca[34]) begin
            cx_nx = r_cx - cy_sh;
            cy_nx = r_cy + cx_sh;
            ca_nx = r_ca - atan_rom(r_cstep);
        end else begin
            cx_nx = r_cx + cy_sh;
            cy_nx = r_cy - cx_sh;
            ca_nx = r_ca + atan_rom(r_cstep);
        end
        cl_x = satq30(68'(r_cx));
        cl_y = satq30(68'(r_cy));
        ang_wrap = (r_aq > PI_A) ? (r_aq - TWO_PI_A) : r_aq;
    end

    // operand select for the shared multiplier
    always_comb begin
        mrow    = {1'b0, r_r, 1'b0} + {2'b00, r_r};
        mat_idx = mrow + {2'b00, r_i};
        rot_idx = {1'b0, r_i, 1'b0} + {2'b00, r_i} + {2'b00, r_k};
        mul_a   = 33'(r_ax);
        mul_b   = 33'(r_ax);
        case (r_state)
            S_ROT: begin
                case (r_u)
                    3'd0: begin mul_a = 33'(r_ax); mul_b = 33'(r_ax); end
                    3'd1: begin mul_a = 33'(r_ax); mul_b = 33'(r_ay); end
                    3'd2: begin mul_a = 33'(r_ay); mul_b = 33'(r_ay); end
                    3'd3: begin mul_a = 33'(r_xx); mul_b = r_t; end
                    3'd4: begin mul_a = 33'(r_xy); mul_b = r_t; end
                    3'd5: begin mul_a = 33'(r_yy); mul_b = r_t; end
                    3'd6: begin mul_a = 33'(r_ay); mul_b = 33'(r_s); end
                    default: begin mul_a = 33'(r_ax); mul_b = 33'(r_s); end
                endcase
            end
            S_MAT: begin
                mul_a = 33'(r_mat[mat_idx]);
                mul_b = 33'(r_rot[rot_idx]);
            end
            S_MID: begin
                mul_a = 33'(r_mat[mat_idx]);
                mul_b = 33'(r_mid[r_i]);
            end
            S_VRAD: begin
                mul_a = $signed({8'b0, r_radius});
                mul_b = r_u[0] ? 33'(r_tsin) : 33'(r_tcos);
            end
            S_VDOT: begin
                mul_a = 33'(r_mat[mrow + {3'b000, r_i[0]}]);
                case (r_i)
                    2'd0:    mul_b = 33'(r_cxv);
                    2'd1:    mul_b = 33'(r_cyv);
                    2'd2:    mul_b = 33'(r_tcos);
                    default: mul_b = 33'(r_tsin);
                endcase
            end
            default: ;
        endcase
        prod_w = 68'(r_prod);
        v30    = rnd30(prod_w);
        acc_in = (r_i == 2'd0) ? 68'sd0 : r_acc;
        sum_r  = acc_in + v30;
        sum_p  = r_acc + prod_w;
        sum_m  = r_acc - prod_w;
    end

    // circle table memory
    always_ff @(posedge i_clk) begin
        if (r_state == S_TAB_WR) begin
            r_tab_cos[r_vi] <= r_c;
            r_tab_sin[r_vi] <= r_s;
        end
        r_tcos <= r_tab_cos[r_vi];
        r_tsin <= r_tab_sin[r_vi];
    end

    // shared multiplier: registered product
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_TAB_LD;
            r_ph      <= 1'b0;
            r_init    <= 1'b1;
            r_u       <= '0;
            r_r       <= '0;
            r_k       <= '0;
            r_i       <= '0;
            r_vi      <= '0;
            r_aq      <= '0;
            r_arem    <= ARW'(ANG_REM0);
            r_cstep   <= '0;
            r_spacing <= SPACING_RST;
            r_radius  <= RADIUS_RST;
            for (int j = 0; j < 9; j++) begin
                r_mat[j] <= (j == 0 || j == 4 || j == 8) ? Q30_ONE : 32'sd0;
            end
            for (int j = 0; j < 3; j++) begin
                r_mid[j] <= '0;
            end
        end else begin
            // configuration beats
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_RING_SPACING: r_spacing <= i_cfg_data;
                    CFG_RING_RADIUS:  r_radius  <= i_cfg_data;
                    default: ;
                endcase
            end

            unique case (r_state)
                // load the next table angle, wrapped into [-pi, pi]
                S_TAB_LD: begin
                    r_ca    <= ang_wrap;
                    r_state <= S_FOLD;
                end
                // fold into [-pi/2, pi/2], negate cos when folded
                S_FOLD: begin
                    if (r_ca > HALF_PI_A) begin
                        r_ca   <= PI_A - r_ca;
                        r_cneg <= 1'b1;
                    end else if (r_ca < -HALF_PI_A) begin
                        r_ca   <= -PI_A - r_ca;
                        r_cneg <= 1'b1;
                    end else begin
                        r_cneg <= 1'b0;
                    end
                    r_cx    <= CORDIC_GAIN;
                    r_cy    <= '0;
                    r_cstep <= '0;
                    r_state <= S_CORD;
                end
                S_CORD: begin
                    r_cx <= cx_nx;
                    r_cy <= cy_nx;
                    r_ca <= ca_nx;
                    if (r_cstep == CSW'(CSTAGES - 1)) begin
                        r_state <= S_CEND;
                    end else begin
                        r_cstep <= r_cstep + 1'b1;
                    end
                end
                // clip, apply fold sign, derive 1 - cos
                S_CEND: begin
                    r_c <= r_cneg ? -cl_x : cl_x;
                    r_s <= cl_y;
                    r_t <= r_cneg ? (33'(Q30_ONE) + 33'(cl_x)) : (33'(Q30_ONE) - 33'(cl_x));
                    r_u  <= '0;
                    r_ph <= 1'b0;
                    r_state <= r_init ? S_TAB_WR : S_ROT;
                end
                // table entry written by the memory block; advance the angle
                S_TAB_WR: begin
                    if (r_arem + ARW'(ANG_STEP_R) >= ARW'(DIV)) begin
                        r_arem <= r_arem + ARW'(ANG_STEP_R) - ARW'(DIV);
                        r_aq   <= r_aq + t_ang'(ANG_STEP_Q + 1);
                    end else begin
                        r_arem <= r_arem + ARW'(ANG_STEP_R);
                        r_aq   <= r_aq + t_ang'(ANG_STEP_Q);
                    end
                    if (r_vi == VW'(NVERT - 1)) begin
                        r_init  <= 1'b0;
                        r_vi    <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_vi    <= r_vi + 1'b1;
                        r_state <= S_TAB_LD;
                    end
                end
                S_IDLE: begin
                    if (in_beat) begin
                        if (i_restart) begin
                            for (int j = 0; j < 9; j++) begin
                                r_mat[j] <= (j == 0 || j == 4 || j == 8) ? Q30_ONE : 32'sd0;
                            end
                            r_mid[0] <= '0;
                            r_mid[1] <= '0;
                            r_mid[2] <= i_start_z;
                        end
                        r_ax    <= satq30(68'(i_axis_x));
                        r_ay    <= satq30(68'(i_axis_y));
                        r_ca    <= 35'(i_rotation_angle);
                        r_state <= S_FOLD;
                    end
                end
                // axis-angle rotation entries
                S_ROT: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        case (r_u)
                            3'd0: r_xx <= v30[31:0];
                            3'd1: r_xy <= v30[31:0];
                            3'd2: r_yy <= v30[31:0];
                            3'd3: r_rot[0] <= sat32(v30 + 68'(r_c));
                            3'd4: begin
                                r_rot[1] <= sat32(v30);
                                r_rot[3] <= sat32(v30);
                            end
                            3'd5: r_rot[4] <= sat32(v30 + 68'(r_c));
                            3'd6: begin
                                r_rot[2] <= sat32(v30);
                                r_rot[6] <= sat32(-v30);
                            end
                            default: begin
                                r_rot[7] <= sat32(v30);
                                r_rot[5] <= sat32(-v30);
                                r_rot[8] <= r_c;
                            end
                        endcase
                        r_u <= r_u + 1'b1;
                        if (r_u == 3'd7) begin
                            r_r <= '0;
                            r_k <= '0;
                            r_i <= '0;
                            r_state <= S_MAT;
                        end
                    end
                end
                // accumulated matrix times rotation, one row at a time
                S_MAT: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_acc <= sum_r;
                        if (r_i == 2'd2) begin
                            r_i <= '0;
                            if (r_k == 2'd2) begin
                                r_mat[mrow]        <= r_row[0];
                                r_mat[mrow + 4'd1] <= r_row[1];
                                r_mat[mrow + 4'd2] <= sat32(sum_r);
                                r_k <= '0;
                                if (r_r == 2'd2) begin
                                    r_r     <= '0;
                                    r_state <= S_MID;
                                end else begin
                                    r_r <= r_r + 1'b1;
                                end
                            end else begin
                                r_row[r_k[0]] <= sat32(sum_r);
                                r_k <= r_k + 1'b1;
                            end
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end
                end
                // midpoint transformed by the new matrix
                S_MID: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        r_acc <= acc_in + prod_w;
                        if (r_i == 2'd2) begin
                            r_i <= '0;
                            if (r_r == 2'd2) begin
                                r_mid[0] <= r_nmid[0];
                                r_mid[1] <= r_nmid[1];
                                r_mid[2] <= sat28(rnd30(acc_in + prod_w));
                                r_r     <= '0;
                                r_vi    <= '0;
                                r_state <= S_VRD;
                            end else begin
                                r_nmid[r_r[0]] <= sat28(rnd30(acc_in + prod_w));
                                r_r <= r_r + 1'b1;
                            end
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end
                end
                // table read latency
                S_VRD: begin
                    r_u     <= '0;
                    r_ph    <= 1'b0;
                    r_state <= S_VRAD;
                end
                // circle point scaled by the radius
                S_VRAD: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        if (r_u[0]) begin
                            r_cyv   <= v30[31:0];
                            r_r     <= '0;
                            r_i     <= '0;
                            r_state <= S_VDOT;
                        end else begin
                            r_cxv <= v30[31:0];
                        end
                        r_u <= r_u + 1'b1;
                    end
                end
                // position and normal, one component per four products
                S_VDOT: begin
                    r_ph <= ~r_ph;
                    if (r_ph) begin
                        case (r_i)
                            2'd0: r_acc <= prod_w;
                            2'd1: r_pos[r_r] <= sat28(rnd30(sum_p) + 68'(r_mid[r_r]));
                            2'd2: r_acc <= -prod_w;
                            default: r_norm[r_r] <= satq30(rnd30(sum_m));
                        endcase
                        r_i <= r_i + 1'b1;
                        if (r_i == 2'd3) begin
                            if (r_r == 2'd2) begin
                                r_state <= S_OUT;
                            end else begin
                                r_r <= r_r + 1'b1;
                            end
                        end
                    end
                end
                // hold the vertex until the beat is taken
                S_OUT: begin
                    if (out_beat) begin
                        if (o_last_vertex) begin
                            r_state <= S_LOWER;
                        end else begin
                            r_vi    <= r_vi + 1'b1;
                            r_state <= S_VRD;
                        end
                    end
                end
                // drop the midpoint by one ring spacing
                S_LOWER: begin
                    r_mid[2] <= sat28(68'(r_mid[2]) - $signed({43'b0, r_spacing}));
                    r_vi     <= '0;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `RCRT_ASSERT(a_in_busy, in_beat |=> !o_in_ready, "input taken while a ring is in work")
    `RCRT_ASSERT(a_vert_step, (out_beat && !o_last_vertex) |=> (r_vi == $past(r_vi) + 1'b1), "vertex index skipped")
    `RCRT_ASSERT(a_last_end, (out_beat && o_last_vertex) |=> !o_out_valid, "beat after last vertex")
    `RCRT_ASSERT_NEVER(a_norm_rng, o_out_valid && (o_norm_x > Q30_ONE || o_norm_x < -Q30_ONE), "normal out of range")

endmodule
`default_nettype wire

@@ verif/ring_chain_rotation_transform_core_tb.sv @@
`timescale 1ns / 1ps
module ring_chain_rotation_transform_core_tb;
    import rcrt_pkg::*;

    // Register indexes the core does not decode; writes to them must be dropped.
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;

    localparam longint ONE      = 64'sd1073741824;
    localparam longint PI_A64   = 64'sd3373259426;
    localparam longint HPI_A64  = 64'sd1686629713;
    localparam longint TPI_A64  = 64'sd6746518852;
    localparam longint GAIN64   = 64'sd652032874;
    localparam longint POS_HI   = 64'sd134217727;
    localparam longint POS_LO   = -64'sd134217728;
    localparam longint W32_HI   = 64'sd2147483647;
    localparam longint W32_LO   = -64'sd2147483648;
    localparam int     DRAIN    = 200;
    localparam int     HOLD_LEN = 3000;
    localparam longint LIMIT    = 64'd6000000;

    localparam longint ARC_STEP [30] = '{
        843314857, 497837830, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2
    };

    typedef struct packed {
        logic               restart;
        logic signed [27:0] z;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] ang;
        logic               zero_pos;   // positions typed in as zero
    } t_ring;

    typedef struct {
        logic signed [27:0] px, py, pz;
        logic signed [31:0] nx, ny, nz;
        logic [5:0]         idx;
        logic               last;
    } t_vertex;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               o_in_ready;
    logic               restart = 1'b0;
    logic signed [27:0] start_z = '0;
    logic signed [31:0] axis_x = '0, axis_y = '0, rot_angle = '0;
    logic               o_out_valid;
    logic               out_ready = 1'b0;
    logic signed [27:0] o_pos_x, o_pos_y, o_pos_z;
    logic signed [31:0] o_norm_x, o_norm_y, o_norm_z;
    logic [5:0]         o_vertex_index;
    logic               o_last_vertex;
    logic               cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [24:0]        cfg_data = '0;

    ring_chain_rotation_transform_core dut (
        .i_clk, .i_rst_n,
        .i_in_valid(in_valid), .o_in_ready,
        .i_restart(restart), .i_start_z(start_z),
        .i_axis_x(axis_x), .i_axis_y(axis_y), .i_rotation_angle(rot_angle),
        .o_out_valid, .i_out_ready(out_ready),
        .o_pos_x, .o_pos_y, .o_pos_z, .o_norm_x, .o_norm_y, .o_norm_z,
        .o_vertex_index, .o_last_vertex,
        .i_cfg_valid(cfg_valid), .o_cfg_ready,
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the core: accumulated matrix, midpoint, registers, circle table.
    longint  tube_mat [9];
    longint  tube_mid [3];
    longint  spacing_q16, radius_q16;
    longint  circ_cos [NVERT];
    longint  circ_sin [NVERT];
    t_vertex pending_vertices [$];
    int      mismatches = 0;
    bit      steady = 1'b0;   // suppress random idling on both sides
    bit      hold_req = 1'b0; // ask the receiver for a long hold-off

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint q30_round(input longint v);
        return (v + 64'sd536870912) >>> 30;
    endfunction

    function automatic longint q30_mul(input longint a, input longint b);
        return q30_round(a * b);
    endfunction

    // Fold the angle into +-pi/2, then rotate a gain-scaled unit vector.
    function automatic void cordic_sin_cos(input longint ang, output longint c,
                                           output longint s);
        longint a, x, y, t;
        bit     flip;
        a = ang;
        x = GAIN64;
        y = 0;
        flip = 1'b0;
        while (a > PI_A64) a -= TPI_A64;
        while (a < -PI_A64) a += TPI_A64;
        if (a > HPI_A64) begin
            a = PI_A64 - a;
            flip = 1'b1;
        end else if (a < -HPI_A64) begin
            a = -PI_A64 - a;
            flip = 1'b1;
        end
        for (int i = 0; i < 30; i++) begin
            if (a >= 0) begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                a -= ARC_STEP[i];
            end else begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                a += ARC_STEP[i];
            end
            x = t;
        end
        x = clip(x, -ONE, ONE);
        y = clip(y, -ONE, ONE);
        c = flip ? -x : x;
        s = y;
    endfunction

    function automatic void tube_reset();
        longint ang;
        spacing_q16 = SPACING_RST;
        radius_q16 = RADIUS_RST;
        for (int i = 0; i < 9; i++) tube_mat[i] = (i % 4 == 0) ? ONE : 0;
        for (int i = 0; i < 3; i++) tube_mid[i] = 0;
        for (int i = 0; i < NVERT; i++) begin
            ang = (TPI_A64 * i + DIV / 2) / DIV;
            cordic_sin_cos(ang, circ_cos[i], circ_sin[i]);
        end
    endfunction

    // Advance the shadow by one ring and queue its vertices.
    function automatic void predict_ring(input t_ring r);
        longint  ax, ay, c, s, t, xx, xy, yy, acc, cx, cy, m0, m1;
        longint  rot [9];
        longint  nm [9];
        longint  nmid [3];
        longint  pv [3];
        longint  nv [3];
        t_vertex v;
        if (r.restart) begin
            for (int i = 0; i < 9; i++) tube_mat[i] = (i % 4 == 0) ? ONE : 0;
            tube_mid[0] = 0;
            tube_mid[1] = 0;
            tube_mid[2] = r.z;
        end
        ax = clip(r.ax, -ONE, ONE);
        ay = clip(r.ay, -ONE, ONE);
        cordic_sin_cos(r.ang, c, s);
        t = ONE - c;
        xx = q30_mul(ax, ax);
        xy = q30_mul(ax, ay);
        yy = q30_mul(ay, ay);
        rot[0] = q30_mul(xx, t) + c;
        rot[1] = q30_mul(xy, t);
        rot[2] = q30_mul(ay, s);
        rot[3] = q30_mul(xy, t);
        rot[4] = q30_mul(yy, t) + c;
        rot[5] = -q30_mul(ax, s);
        rot[6] = -q30_mul(ay, s);
        rot[7] = q30_mul(ax, s);
        rot[8] = c;
        for (int i = 0; i < 9; i++) rot[i] = clip(rot[i], W32_LO, W32_HI);
        for (int row = 0; row < 3; row++)
            for (int col = 0; col < 3; col++) begin
                acc = 0;
                for (int i = 0; i < 3; i++)
                    acc += q30_mul(tube_mat[row * 3 + i], rot[i * 3 + col]);
                nm[row * 3 + col] = clip(acc, W32_LO, W32_HI);
            end
        tube_mat = nm;
        for (int row = 0; row < 3; row++) begin
            acc = tube_mat[row * 3] * tube_mid[0] + tube_mat[row * 3 + 1] * tube_mid[1]
                + tube_mat[row * 3 + 2] * tube_mid[2];
            nmid[row] = clip(q30_round(acc), POS_LO, POS_HI);
        end
        tube_mid = nmid;
        for (int i = 0; i < NVERT; i++) begin
            cx = q30_mul(radius_q16, circ_cos[i]);
            cy = q30_mul(radius_q16, circ_sin[i]);
            for (int row = 0; row < 3; row++) begin
                m0 = tube_mat[row * 3];
                m1 = tube_mat[row * 3 + 1];
                pv[row] = clip(q30_round(m0 * cx + m1 * cy) + tube_mid[row], POS_LO, POS_HI);
                nv[row] = clip(q30_round(-(m0 * circ_cos[i]) - m1 * circ_sin[i]), -ONE, ONE);
            end
            v.px = r.zero_pos ? 28'sd0 : 28'(pv[0]);
            v.py = r.zero_pos ? 28'sd0 : 28'(pv[1]);
            v.pz = r.zero_pos ? 28'sd0 : 28'(pv[2]);
            v.nx = 32'(nv[0]);
            v.ny = 32'(nv[1]);
            v.nz = 32'(nv[2]);
            v.idx = 6'(i);
            v.last = (i == RING_STEPS);
            pending_vertices.push_back(v);
        end
        tube_mid[2] = clip(tube_mid[2] - spacing_q16, POS_LO, POS_HI);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // Receiver: check each vertex beat at the rising edge, pick ready at the falling edge.
    initial begin
        t_vertex w;
        int      held;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && out_ready) begin
                if (pending_vertices.size() == 0) begin
                    report_mismatch("unexpected vertex", o_vertex_index, -1);
                end else begin
                    w = pending_vertices.pop_front();
                    if (o_pos_x !== w.px) report_mismatch("pos_x", o_pos_x, w.px);
                    if (o_pos_y !== w.py) report_mismatch("pos_y", o_pos_y, w.py);
                    if (o_pos_z !== w.pz) report_mismatch("pos_z", o_pos_z, w.pz);
                    if (o_norm_x !== w.nx) report_mismatch("norm_x", o_norm_x, w.nx);
                    if (o_norm_y !== w.ny) report_mismatch("norm_y", o_norm_y, w.ny);
                    if (o_norm_z !== w.nz) report_mismatch("norm_z", o_norm_z, w.nz);
                    if (o_vertex_index !== w.idx)
                        report_mismatch("vertex_index", o_vertex_index, w.idx);
                    if (o_last_vertex !== w.last)
                        report_mismatch("last_vertex", o_last_vertex, w.last);
                end
            end
            @(negedge i_clk);
            if (hold_req) begin
                // Stall the output long enough for the core to back up onto its input.
                out_ready = 1'b0;
                for (held = 0; held < HOLD_LEN; held++) @(negedge i_clk);
                hold_req = 1'b0;
            end
            out_ready = steady || ($urandom_range(0, 99) >= 21);
        end
    end

    // Watchdog on total run length.
    initial begin
        longint cycles;
        for (cycles = 0; cycles < LIMIT; cycles++) @(posedge i_clk);
        $display("== FAIL ==");
        $finish;
    end

    // Offer one ring beat; hold valid and payload until the core takes it.
    task automatic send_ring(input t_ring r);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < 21) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid = 1'b1;
        restart = r.restart;
        start_z = r.z;
        axis_x = r.ax;
        axis_y = r.ay;
        rot_angle = r.ang;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_ring(r);
    endtask

    // Drop valid, let every queued vertex arrive, then let the core settle.
    task automatic wait_idle();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (pending_vertices.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [24:0] val);
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_RING_SPACING) spacing_q16 = val;
        else if (idx == CFG_RING_RADIUS) radius_q16 = val;
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    // Mostly well-formed rings with in-range axis and angle; some raw noise.
    function automatic t_ring random_ring();
        t_ring r;
        r.restart = ($urandom_range(0, 7) == 0);
        r.z = 28'($urandom);
        r.zero_pos = 1'b0;
        if ($urandom_range(0, 99) < 80) begin
            r.ax = 32'(longint'($urandom_range(0, 32'h80000000)) - ONE);
            r.ay = 32'(longint'($urandom_range(0, 32'h80000000)) - ONE);
            r.ang = 32'(longint'($urandom_range(0, 32'hC90FDAA2)) - HPI_A64);
            if ($urandom_range(0, 3) == 0) r.z = $signed(r.z) >>> 8;
        end else begin
            r.ax = $urandom;
            r.ay = $urandom;
            r.ang = $urandom;
        end
        return r;
    endfunction

    t_ring directed_rings [14] = '{
        // no restart yet: reset matrix and zero midpoint, radius zero
        '{1'b0, 28'sd12345, 32'sd0, 32'sd0, 32'sd0, 1'b1},
        '{1'b1, 28'sd0, 32'sd1073741824, 32'sd0, 32'sd1686629713, 1'b1},
        '{1'b1, 28'sh7ffffff, 32'sd1073741824, 32'sd0, 32'sd1686629713, 1'b0},
        '{1'b1, 28'sh8000000, -32'sd1073741824, -32'sd1073741824, -32'sd1686629713, 1'b0},
        // axis beyond unit length and angle beyond a quarter turn
        '{1'b0, 28'sd0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b0},
        '{1'b0, 28'sd0, 32'sd0, 32'sd1073741824, 32'sh80000000, 1'b0},
        // diagonal axis repeated: matrix entries grow until they saturate
        '{1'b1, 28'sd0, 32'sd1073741824, 32'sd1073741824, 32'sd1686629713, 1'b0},
        '{1'b0, 28'sd0, 32'sd1073741824, 32'sd1073741824, 32'sd1686629713, 1'b0},
        '{1'b0, 28'sd0, 32'sd1073741824, 32'sd1073741824, 32'sd1686629713, 1'b0},
        '{1'b1, 28'sh7ffffff, 32'sd0, 32'sd0, 32'sd0, 1'b0},
        '{1'b0, 28'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0},
        // lowering z from the bottom of the range saturates
        '{1'b1, 28'sh8000000, 32'sd0, 32'sd0, 32'sd0, 1'b0},
        '{1'b0, 28'sd0, 32'sd0, 32'sd0, -32'sd1, 1'b0},
        '{1'b1, -28'sd1, 32'sd536870912, -32'sd536870912, 32'sd12345, 1'b0}
    };

    logic [24:0] phase_spacing [5] = '{25'd0, 25'h1ffffff, 25'd16777216, 25'd65536, 25'd262144};
    logic [24:0] phase_radius [5]  = '{25'h1ffffff, 25'd0, 25'd16777216, 25'd655360, 25'd1310720};

    initial begin
        tube_reset();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: first two rings with zero radius so every position is zero.
        write_register(CFG_RING_RADIUS, 25'd0);
        for (int i = 0; i < 14; i++) begin
            if (i == 2) begin
                wait_idle();
                write_register(CFG_RING_RADIUS, RADIUS_RST);
            end
            send_ring(directed_rings[i]);
        end
        wait_idle();

        // Random phases, each under its own register setting.
        for (int p = 0; p < 5; p++) begin
            write_register(CFG_RING_SPACING, phase_spacing[p]);
            write_register(CFG_RING_RADIUS, phase_radius[p]);
            write_register((p % 2) ? CFG_SPARE_A : CFG_SPARE_B, 25'($urandom));
            steady = (p == 3);
            if (p == 1) hold_req = 1'b1;
            for (int n = 0; n < 94; n++) begin
                if (p == 2 && n == 47) begin
                    // pause the sender until the pipeline has fully drained
                    @(negedge i_clk);
                    in_valid = 1'b0;
                    while (pending_vertices.size() != 0) @(posedge i_clk);
                end
                send_ring(random_ring());
            end
            wait_idle();
        end
        steady = 1'b0;

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
